// ===== rtl/cei_pkg.sv =====
// Package for the charge and energy integrator: shared types and constants.
// Used by the serial arithmetic units and the top level; depends on nothing.

package cei_pkg;

	// Width of the divider's partial remainder. Both divisors stay below 2^42.
	localparam int unsigned REM_W = 43;

	// uA*ms in one uAh, and uA*uV*ms in one uWh.
	localparam logic [REM_W-1:0] UAH_DIV = 43'd3600000;
	localparam logic [REM_W-1:0] UWH_DIV = 43'd3600000000000;

	// Stored charge remainder width (magnitude below 3.6e6).
	localparam int unsigned CREM_W = 23;

	// Status that a serial unit reports back to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

// ===== rtl/cei_sample_if.sv =====
// Request channel that carries one sample into the integrator.
// Valid/ready handshake; no package dependency.

interface cei_sample_if;
	logic               valid;
	logic               ready;
	logic        [31:0] now_ms;
	logic signed [31:0] cur_ua;
	logic        [26:0] vbus_uv;
	logic               meas_ok;

	modport source (output valid, output now_ms, output cur_ua,
		output vbus_uv, output meas_ok, input ready);
	modport sink (input valid, input now_ms, input cur_ua,
		input vbus_uv, input meas_ok, output ready);
endinterface

// ===== rtl/cei_result_if.sv =====
// Request channel that carries the two running totals out of the integrator.
// Valid/ready handshake; no package dependency.

interface cei_result_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] charge_uah;
	logic signed [63:0] energy_uwh;

	modport source (output valid, output charge_uah, output energy_uwh, input ready);
	modport sink (input valid, input charge_uah, input energy_uwh, output ready);
endinterface

// ===== rtl/cei_serial_mul.sv =====
// Shift-and-add multiplier: 64-bit multiplicand by 32-bit multiplier, mod 2^64,
// one multiplier bit per cycle. Depends on cei_pkg for the status struct.

module cei_serial_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [63:0]       mcand,
	input  logic [31:0]       mplier,
	output logic [63:0]       product,
	output cei_pkg::unit_stat_t stat
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] a_q;
	logic [31:0] b_q;
	logic [63:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= mcand;
			b_q   <= mplier;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[62:0], 1'b0};
			b_q <= {1'b0, b_q[31:1]};
		end
	end

	assign product   = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/cei_serial_div.sv =====
// Restoring divider: signed 64-bit dividend by one of two constant divisors,
// one quotient bit per cycle, truncating toward zero. Depends on cei_pkg.

module cei_serial_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             sel_energy,
	input  logic [63:0]                      dividend,
	output logic [63:0]                      quotient,
	output logic [cei_pkg::REM_W-1:0]        remainder,
	output cei_pkg::unit_stat_t              stat
);

	logic                      busy_q;
	logic                      fix_q;
	logic                      done_q;
	logic [5:0]                cnt_q;
	logic                      neg_q;
	logic                      sel_q;
	logic [63:0]               dq_q;
	logic [cei_pkg::REM_W-1:0] r_q;
	logic [63:0]               quo_q;
	logic [cei_pkg::REM_W-1:0] rem_q;

	logic [cei_pkg::REM_W-1:0] divisor;
	logic [cei_pkg::REM_W-1:0] trial;
	logic                      fits;

	assign divisor = sel_q ? cei_pkg::UWH_DIV : cei_pkg::UAH_DIV;
	assign trial   = {r_q[cei_pkg::REM_W-2:0], dq_q[63]};
	assign fits    = (trial >= divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				fix_q  <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q && fix_q) begin
				busy_q <= 1'b0;
				fix_q  <= 1'b0;
				done_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					fix_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[63];
			sel_q <= sel_energy;
			dq_q  <= dividend[63] ? (64'd0 - dividend) : dividend;
			r_q   <= '0;
		end else if (busy_q && fix_q) begin
			// Quotient and remainder both take the sign of the dividend.
			quo_q <= neg_q ? (64'd0 - dq_q) : dq_q;
			rem_q <= neg_q ? ({cei_pkg::REM_W{1'b0}} - r_q) : r_q;
		end else if (busy_q) begin
			r_q  <= fits ? (trial - divisor) : trial;
			dq_q <= {dq_q[62:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/charge_energy_integrator_core.sv =====
// Coulomb counter and energy meter. An item with a valid sample and a nonzero
// elapsed time takes three passes of the bit-serial multiplier (current
// times elapsed time, current times voltage, that product times elapsed time)
// and two passes of the restoring divider (by 3.6e6 for uAh and 3.6e12 for
// uWh); the uAh division comes before the second multiply. An item with zero
// elapsed time or an invalid sample skips them and goes to the output step.
// One item is worked at a time; a new request is taken only while the
// sequencer is idle, but a finished result may still wait in the output
// register while the next request is accepted.
// Elapsed time is the modulo-2^32 difference of the request's timestamp and
// the stored last update time. Products and sums wrap in 64-bit two's
// complement, division truncates toward zero, and the remainders keep the sign
// of their dividends. Every request returns both totals.
// Depends on cei_pkg, cei_sample_if, cei_result_if, cei_serial_mul and
// cei_serial_div.

module charge_energy_integrator_core (
	input  logic         clk,
	input  logic         arst_n,
	cei_sample_if.sink   sample,
	cei_result_if.source result
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_C_MUL = 9'b000000010,
		ST_C_DGO = 9'b000000100,
		ST_C_DIV = 9'b000001000,
		ST_P_MUL = 9'b000010000,
		ST_E_MUL = 9'b000100000,
		ST_E_DGO = 9'b001000000,
		ST_E_DIV = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t state_q;

	// Architectural state.
	logic        [31:0]                last_q;
	logic        [cei_pkg::CREM_W-1:0] crem_q;
	logic        [cei_pkg::REM_W-1:0]  erem_q;
	logic        [63:0]                ctot_q;
	logic        [63:0]                etot_q;

	// Per-request working registers.
	logic        [31:0] cur_q;
	logic        [26:0] volt_q;
	logic        [31:0] dt_q;
	logic        [63:0] dividend_q;

	// Output register.
	logic               out_valid_q;
	logic        [63:0] out_charge_q;
	logic        [63:0] out_energy_q;
	logic               out_load;

	logic        [31:0] dt;
	logic               accept;

	logic               mul_start;
	logic        [63:0] mul_mcand;
	logic        [31:0] mul_mplier;
	logic        [63:0] mul_product;
	cei_pkg::unit_stat_t mul_stat;

	logic               div_start;
	logic        [63:0] div_quo;
	logic [cei_pkg::REM_W-1:0] div_rem;
	cei_pkg::unit_stat_t div_stat;

	assign dt           = sample.now_ms - last_q;
	assign sample.ready = (state_q == ST_IDLE);
	assign accept       = sample.valid && sample.ready;

	// The output register is loaded in the output step once it is free or
	// its current result leaves in the same cycle.
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || result.ready);

	// The multiplier is launched from three places; each picks its operands.
	always_comb begin
		mul_start  = 1'b0;
		mul_mcand  = {{32{sample.cur_ua[31]}}, sample.cur_ua};
		mul_mplier = dt;
		unique case (state_q)
			ST_IDLE: begin
				mul_start = accept && sample.meas_ok && (dt != 32'd0);
			end
			ST_C_DIV: begin
				mul_start  = div_stat.done;
				mul_mcand  = {{32{cur_q[31]}}, cur_q};
				mul_mplier = {5'd0, volt_q};
			end
			ST_P_MUL: begin
				mul_start  = mul_stat.done;
				mul_mcand  = mul_product;
				mul_mplier = dt_q;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	assign div_start = (state_q == ST_C_DGO) || (state_q == ST_E_DGO);

	cei_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mul_mcand),
		.mplier  (mul_mplier),
		.product (mul_product),
		.stat    (mul_stat)
	);

	cei_serial_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.sel_energy (state_q == ST_E_DGO),
		.dividend   (dividend_q),
		.quotient   (div_quo),
		.remainder  (div_rem),
		.stat       (div_stat)
	);

	// Sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= '0;
			crem_q      <= '0;
			erem_q      <= '0;
			ctot_q      <= '0;
			etot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (dt != 32'd0) begin
							last_q <= sample.now_ms;
						end
						state_q <= mul_start ? ST_C_MUL : ST_OUT;
					end
				end
				ST_C_MUL: begin
					if (mul_stat.done) begin
						state_q <= ST_C_DGO;
					end
				end
				ST_C_DGO: begin
					state_q <= ST_C_DIV;
				end
				ST_C_DIV: begin
					if (div_stat.done) begin
						ctot_q  <= ctot_q + div_quo;
						crem_q  <= div_rem[cei_pkg::CREM_W-1:0];
						state_q <= ST_P_MUL;
					end
				end
				ST_P_MUL: begin
					if (mul_stat.done) begin
						state_q <= ST_E_MUL;
					end
				end
				ST_E_MUL: begin
					if (mul_stat.done) begin
						state_q <= ST_E_DGO;
					end
				end
				ST_E_DGO: begin
					state_q <= ST_E_DIV;
				end
				ST_E_DIV: begin
					if (div_stat.done) begin
						etot_q  <= etot_q + div_quo;
						erem_q  <= div_rem;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// Load the output register once the previous result is gone.
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working and output payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q  <= sample.cur_ua;
			volt_q <= sample.vbus_uv;
			dt_q   <= dt;
		end
		if ((state_q == ST_C_MUL) && mul_stat.done) begin
			dividend_q <= {{(64-cei_pkg::CREM_W){crem_q[cei_pkg::CREM_W-1]}}, crem_q}
				+ mul_product;
		end
		if ((state_q == ST_E_MUL) && mul_stat.done) begin
			dividend_q <= {{(64-cei_pkg::REM_W){erem_q[cei_pkg::REM_W-1]}}, erem_q}
				+ mul_product;
		end
		if (out_load) begin
			out_charge_q <= ctot_q;
			out_energy_q <= etot_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.charge_uah = out_charge_q;
	assign result.energy_uwh = out_energy_q;

	// The two serial units never run at the same time.
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_stat.busy && div_stat.busy))
		else $error("multiplier and divider busy together");

	// A request with zero elapsed time leaves the stored time alone.
	a_zero_dt_keeps_time: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (dt == 32'd0)) |=> ($stable(last_q) && (state_q == ST_OUT)))
		else $error("zero elapsed time changed state");

	// The multiplier only reports completion to a state that waits for it.
	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> ((state_q == ST_C_MUL) || (state_q == ST_P_MUL)
			|| (state_q == ST_E_MUL)))
		else $error("multiplier done outside a multiply state");

	// The stored charge remainder stays below one uAh in magnitude.
	a_crem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		($signed({{(cei_pkg::REM_W-cei_pkg::CREM_W){crem_q[cei_pkg::CREM_W-1]}}, crem_q})
			< $signed(cei_pkg::UAH_DIV))
		&& ($signed({{(cei_pkg::REM_W-cei_pkg::CREM_W){crem_q[cei_pkg::CREM_W-1]}}, crem_q})
			> -$signed(cei_pkg::UAH_DIV)))
		else $error("charge remainder out of range");

	// A result that has been taken is followed by a fresh one only from the output step.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("output loaded outside the output step");

endmodule
